// ===== rtl/greedy_tour_edge_selector_macros.svh =====
// assertion macros shared by the rtl that checks itself
`ifndef GREEDY_TOUR_EDGE_SELECTOR_MACROS_SVH
`define GREEDY_TOUR_EDGE_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle as the trigger
`define GTES_ASSERT_NOW(label, clk, rst_n, trig, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
		else $error("gtes check failed");
// condition holds in the cycle after the trigger
`define GTES_ASSERT_NEXT(label, clk, rst_n, trig, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
		else $error("gtes check failed");
`else
`define GTES_ASSERT_NOW(label, clk, rst_n, trig, expr)
`define GTES_ASSERT_NEXT(label, clk, rst_n, trig, expr)
`endif

`endif

// ===== rtl/gtes_pkg.sv =====
package gtes_pkg;

	// field widths
	localparam int REQ_W    = 2;
	localparam int END_W    = 8;
	localparam int VCOUNT_W = 9;
	localparam int RANK_W   = 4;
	localparam int DEG_W    = 2;

	localparam int MAX_VERTICES_DEF = 256;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;

	// request codes
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MATCH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CAND  = 2'd2;

	// saturation and limits
	localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;
	localparam logic [DEG_W-1:0]  DEG_MAX   = 2'd3;
	localparam logic [DEG_W-1:0]  DEG_LIMIT = 2'd2;

	// forest unit commands
	typedef struct packed {
		logic clr;
		logic find;
		logic link;
	} forest_cmd_t;

	// degree unit commands
	typedef struct packed {
		logic clr;
		logic rd;
		logic bump;
	} deg_cmd_t;

endpackage

// ===== rtl/gtes_if.sv =====
// request channel
interface gtes_req_if;
	logic                         valid;
	logic                         ready;
	logic [gtes_pkg::REQ_W-1:0]   req_type;
	logic [gtes_pkg::END_W-1:0]   end_a;
	logic [gtes_pkg::END_W-1:0]   end_b;
	logic                         edge_in_matching;

	modport source (output valid, req_type, end_a, end_b, edge_in_matching, input ready);
	modport sink (input valid, req_type, end_a, end_b, edge_in_matching, output ready);
endinterface

// result channel
interface gtes_res_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [gtes_pkg::VCOUNT_W-1:0] chosen_edges;
	logic                          tour_done;

	modport source (output valid, accepted, chosen_edges, tour_done, input ready);
	modport sink (input valid, accepted, chosen_edges, tour_done, output ready);
endinterface

// ===== rtl/gtes_forest.sv =====
module gtes_forest #(
	parameter int MAX_VERTICES = gtes_pkg::MAX_VERTICES_DEF,
	localparam int VW = $clog2(MAX_VERTICES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gtes_pkg::forest_cmd_t         cmd,
	input  logic [VW-1:0]                 clr_addr,
	input  logic [VW-1:0]                 find_v,
	input  logic [VW-1:0]                 link_x,
	input  logic [VW-1:0]                 link_y,
	input  logic [gtes_pkg::RANK_W-1:0]   rank_x,
	input  logic [gtes_pkg::RANK_W-1:0]   rank_y,
	output logic                          done,
	output logic [VW-1:0]                 root,
	output logic [gtes_pkg::RANK_W-1:0]   root_rank
);

	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_UP    = 2'd1;
	localparam logic [1:0] F_DOWN  = 2'd2;
	localparam logic [1:0] F_LINK2 = 2'd3;

	typedef struct packed {
		logic [gtes_pkg::RANK_W-1:0] rank;
		logic [VW-1:0]               parent;
	} node_t;

	node_t mem [MAX_VERTICES];
	node_t rd_q;

	logic [1:0]    state_q, state_d;
	logic [VW-1:0] cur_q, cur_d;
	logic [VW-1:0] v_q, v_d;
	logic [VW-1:0] root_q, root_d;
	logic [gtes_pkg::RANK_W-1:0] rank_q, rank_d;
	logic          done_q, done_d;

	logic          rd_en;
	logic [VW-1:0] rd_addr;
	logic          wr_en;
	logic [VW-1:0] wr_addr;
	node_t         wr_data;

	// parent and rank store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// clear a node, link two roots by rank, or walk up to the root, then walk again pointing every node at it
	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		v_d     = v_q;
		root_d  = root_q;
		rank_d  = rank_q;
		done_d  = 1'b0;
		rd_en   = 1'b0;
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = rd_q;
		case (state_q)
			F_IDLE: begin
				if (cmd.clr) begin
					wr_en   = 1'b1;
					wr_addr = clr_addr;
					wr_data = {{gtes_pkg::RANK_W{1'b0}}, clr_addr};
				end else if (cmd.find) begin
					rd_en   = 1'b1;
					rd_addr = find_v;
					cur_d   = find_v;
					v_d     = find_v;
					state_d = F_UP;
				end else if (cmd.link) begin
					wr_en = 1'b1;
					if (rank_x < rank_y) begin
						wr_addr = link_x;
						wr_data = {rank_x, link_y};
						done_d  = 1'b1;
					end else begin
						wr_addr = link_y;
						wr_data = {rank_y, link_x};
						if (rank_x == rank_y) begin
							state_d = F_LINK2;
						end else begin
							done_d = 1'b1;
						end
					end
				end
			end
			F_UP: begin
				if (rd_q.parent == cur_q) begin
					root_d = cur_q;
					rank_d = rd_q.rank;
					if (v_q == cur_q) begin
						done_d  = 1'b1;
						state_d = F_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = v_q;
						cur_d   = v_q;
						state_d = F_DOWN;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_q.parent;
					cur_d   = rd_q.parent;
				end
			end
			F_DOWN: begin
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_data = {rd_q.rank, root_q};
				if (rd_q.parent == root_q) begin
					done_d  = 1'b1;
					state_d = F_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_q.parent;
					cur_d   = rd_q.parent;
				end
			end
			F_LINK2: begin
				// equal ranks: the surviving root gains one rank, saturating at RANK_MAX
				wr_en   = 1'b1;
				wr_addr = link_x;
				wr_data = {(rank_x == gtes_pkg::RANK_MAX) ? rank_x
					: rank_x + gtes_pkg::RANK_W'(1), link_x};
				done_d  = 1'b1;
				state_d = F_IDLE;
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// walk pointers and result
	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		v_q    <= v_d;
		root_q <= root_d;
		rank_q <= rank_d;
	end

	assign done      = done_q;
	assign root      = root_q;
	assign root_rank = rank_q;

endmodule

// ===== rtl/gtes_degree.sv =====
module gtes_degree #(
	parameter int MAX_VERTICES = gtes_pkg::MAX_VERTICES_DEF,
	localparam int VW = $clog2(MAX_VERTICES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gtes_pkg::deg_cmd_t           cmd,
	input  logic [VW-1:0]                clr_addr,
	input  logic [VW-1:0]                addr_a,
	input  logic [VW-1:0]                addr_b,
	output logic                         done,
	output logic [gtes_pkg::DEG_W-1:0]   deg_a,
	output logic [gtes_pkg::DEG_W-1:0]   deg_b
);

	localparam logic [1:0] D_IDLE  = 2'd0;
	localparam logic [1:0] D_RDB   = 2'd1;
	localparam logic [1:0] D_RDW   = 2'd2;
	localparam logic [1:0] D_BUMP2 = 2'd3;

	logic [gtes_pkg::DEG_W-1:0] mem [MAX_VERTICES];
	logic [gtes_pkg::DEG_W-1:0] rd_q;

	logic [1:0] state_q, state_d;
	logic       done_q, done_d;
	logic [gtes_pkg::DEG_W-1:0] deg_a_q, deg_a_d;
	logic [gtes_pkg::DEG_W-1:0] deg_b_q, deg_b_d;
	logic [gtes_pkg::DEG_W-1:0] inc_a, b_base, inc_b;

	logic          rd_en;
	logic [VW-1:0] rd_addr;
	logic          wr_en;
	logic [VW-1:0] wr_addr;
	logic [gtes_pkg::DEG_W-1:0] wr_data;

	// degree store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// saturating increments; a self loop raises the same vertex twice
	assign inc_a  = (deg_a_q == gtes_pkg::DEG_MAX) ? deg_a_q
		: deg_a_q + gtes_pkg::DEG_W'(1);
	assign b_base = (addr_a == addr_b) ? inc_a : deg_b_q;
	assign inc_b  = (b_base == gtes_pkg::DEG_MAX) ? b_base
		: b_base + gtes_pkg::DEG_W'(1);

	// clear one entry, read both ends, or write both bumped degrees
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		deg_a_d = deg_a_q;
		deg_b_d = deg_b_q;
		rd_en   = 1'b0;
		rd_addr = addr_a;
		wr_en   = 1'b0;
		wr_addr = addr_a;
		wr_data = inc_a;
		case (state_q)
			D_IDLE: begin
				if (cmd.clr) begin
					wr_en   = 1'b1;
					wr_addr = clr_addr;
					wr_data = '0;
				end else if (cmd.rd) begin
					rd_en   = 1'b1;
					state_d = D_RDB;
				end else if (cmd.bump) begin
					wr_en   = 1'b1;
					state_d = D_BUMP2;
				end
			end
			D_RDB: begin
				rd_en   = 1'b1;
				rd_addr = addr_b;
				deg_a_d = rd_q;
				state_d = D_RDW;
			end
			D_RDW: begin
				deg_b_d = rd_q;
				done_d  = 1'b1;
				state_d = D_IDLE;
			end
			D_BUMP2: begin
				wr_en   = 1'b1;
				wr_addr = addr_b;
				wr_data = inc_b;
				done_d  = 1'b1;
				state_d = D_IDLE;
			end
			default: begin
				state_d = D_IDLE;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// captured degrees
	always_ff @(posedge clk) begin
		deg_a_q <= deg_a_d;
		deg_b_q <= deg_b_d;
	end

	assign done  = done_q;
	assign deg_a = deg_a_q;
	assign deg_b = deg_b_q;

endmodule

// ===== rtl/greedy_tour_edge_selector.sv =====
// channel | dir | handshake    | payload
// req     | in  | valid/ready  | req_type, end_a, end_b, edge_in_matching
// res     | out | valid/ready  | accepted, chosen_edges, tour_done
// cfg     | in  | cfg_wr_en    | cfg_wr_data (vertex_count)
//
// one request at a time; each accepted edge reads both degrees, walks from end_a
// and from end_b to their roots (single read port of the parent store), links the
// roots when they differ, raising a rank when the ranks tie, then bumps both degrees
// a clear request sweeps both stores before its result beat
// after reset the same sweep runs with req.ready low
// the result register holds one finished beat while a new request is taken
`include "greedy_tour_edge_selector_macros.svh"

module greedy_tour_edge_selector #(
	parameter int MAX_VERTICES = gtes_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gtes_req_if.sink                      req,
	gtes_res_if.source                    res,
	input  logic                          cfg_wr_en,
	input  logic [gtes_pkg::VCOUNT_W-1:0] cfg_wr_data
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int CW  = gtes_pkg::VCOUNT_W;
	localparam int RW  = gtes_pkg::RANK_W;
	localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTICES - 1);

	localparam logic [3:0] T_SWEEP     = 4'd0;
	localparam logic [3:0] T_IDLE      = 4'd1;
	localparam logic [3:0] T_DEG_GO    = 4'd2;
	localparam logic [3:0] T_DEG_WAIT  = 4'd3;
	localparam logic [3:0] T_FA_GO     = 4'd4;
	localparam logic [3:0] T_FA_WAIT   = 4'd5;
	localparam logic [3:0] T_FB_GO     = 4'd6;
	localparam logic [3:0] T_FB_WAIT   = 4'd7;
	localparam logic [3:0] T_DECIDE    = 4'd8;
	localparam logic [3:0] T_LINK_GO   = 4'd9;
	localparam logic [3:0] T_LINK_WAIT = 4'd10;
	localparam logic [3:0] T_BUMP_GO   = 4'd11;
	localparam logic [3:0] T_BUMP_WAIT = 4'd12;
	localparam logic [3:0] T_RESULT    = 4'd13;

	logic [3:0]    state_q;
	logic [VW-1:0] sweep_q;
	logic          sweep_res_q;
	logic [CW-1:0] vcount_q;
	logic [CW-1:0] edge_total_q;
	logic          acc_q;

	logic [gtes_pkg::REQ_W-1:0] req_q;
	logic [VW-1:0] a_q, b_q;
	logic          match_q;
	logic [VW-1:0] x_q, y_q;
	logic [RW-1:0] rx_q, ry_q;

	logic          res_valid_q;
	logic          res_acc_q;
	logic [CW-1:0] res_chosen_q;
	logic          res_done_q;

	logic [CW-1:0] n_eff;
	logic          ends_ok;
	logic          in_fire;
	logic          out_load;
	logic          f_waiting;
	logic          d_waiting;

	gtes_pkg::forest_cmd_t fcmd;
	gtes_pkg::deg_cmd_t    dcmd;
	logic          f_done, d_done;
	logic [VW-1:0] f_root;
	logic [RW-1:0] f_rank;
	logic [VW-1:0] find_v;
	logic [gtes_pkg::DEG_W-1:0] deg_a, deg_b;

	// effective vertex count and range check of the incoming ends
	assign n_eff   = (32'(vcount_q) < MAX_VERTICES) ? vcount_q : CW'(MAX_VERTICES);
	assign ends_ok = (CW'(req.end_a) < n_eff) && (CW'(req.end_b) < n_eff);

	assign req.ready = (state_q == T_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign out_load  = (state_q == T_RESULT) && (!res_valid_q || res.ready);

	// unit commands
	always_comb begin
		fcmd      = '0;
		dcmd      = '0;
		fcmd.clr  = (state_q == T_SWEEP);
		dcmd.clr  = (state_q == T_SWEEP);
		fcmd.find = (state_q == T_FA_GO) || (state_q == T_FB_GO);
		fcmd.link = (state_q == T_LINK_GO);
		dcmd.rd   = (state_q == T_DEG_GO);
		dcmd.bump = (state_q == T_BUMP_GO);
	end

	assign find_v = (state_q == T_FB_GO) ? b_q : a_q;

	gtes_forest #(.MAX_VERTICES(MAX_VERTICES)) u_forest (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (fcmd),
		.clr_addr  (sweep_q),
		.find_v    (find_v),
		.link_x    (x_q),
		.link_y    (y_q),
		.rank_x    (rx_q),
		.rank_y    (ry_q),
		.done      (f_done),
		.root      (f_root),
		.root_rank (f_rank)
	);

	gtes_degree #(.MAX_VERTICES(MAX_VERTICES)) u_degree (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dcmd),
		.clr_addr (sweep_q),
		.addr_a   (a_q),
		.addr_b   (b_q),
		.done     (d_done),
		.deg_a    (deg_a),
		.deg_b    (deg_b)
	);

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= gtes_pkg::VCOUNT_RESET;
		end else if (cfg_wr_en) begin
			vcount_q <= cfg_wr_data;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_SWEEP;
			sweep_q      <= '0;
			sweep_res_q  <= 1'b0;
			edge_total_q <= '0;
			acc_q        <= 1'b0;
		end else begin
			case (state_q)
				T_SWEEP: begin
					sweep_q <= sweep_q + VW'(1);
					if (sweep_q == LAST_V) begin
						acc_q   <= 1'b0;
						state_q <= sweep_res_q ? T_RESULT : T_IDLE;
					end
				end
				T_IDLE: begin
					if (in_fire) begin
						acc_q <= 1'b0;
						if (req.req_type == gtes_pkg::REQ_CLEAR) begin
							sweep_q      <= '0;
							sweep_res_q  <= 1'b1;
							edge_total_q <= '0;
							state_q      <= T_SWEEP;
						end else if ((req.req_type inside {gtes_pkg::REQ_MATCH,
							gtes_pkg::REQ_CAND}) && ends_ok) begin
							state_q <= T_DEG_GO;
						end else begin
							state_q <= T_RESULT;
						end
					end
				end
				T_DEG_GO: state_q <= T_DEG_WAIT;
				T_DEG_WAIT: begin
					if (d_done) begin
						if (req_q == gtes_pkg::REQ_CAND && (match_q
							|| deg_a >= gtes_pkg::DEG_LIMIT
							|| deg_b >= gtes_pkg::DEG_LIMIT)) begin
							state_q <= T_RESULT;
						end else begin
							state_q <= T_FA_GO;
						end
					end
				end
				T_FA_GO: state_q <= T_FA_WAIT;
				T_FA_WAIT: begin
					if (f_done) state_q <= T_FB_GO;
				end
				T_FB_GO: state_q <= T_FB_WAIT;
				T_FB_WAIT: begin
					if (f_done) state_q <= T_DECIDE;
				end
				T_DECIDE: begin
					// a cycle-closing candidate only once the tour lacks just its last edge
					if (req_q == gtes_pkg::REQ_CAND && x_q == y_q
						&& edge_total_q < (n_eff - CW'(1))) begin
						state_q <= T_RESULT;
					end else if (x_q != y_q) begin
						state_q <= T_LINK_GO;
					end else begin
						state_q <= T_BUMP_GO;
					end
				end
				T_LINK_GO: state_q <= T_LINK_WAIT;
				T_LINK_WAIT: begin
					if (f_done) state_q <= T_BUMP_GO;
				end
				T_BUMP_GO: state_q <= T_BUMP_WAIT;
				T_BUMP_WAIT: begin
					if (d_done) begin
						acc_q <= 1'b1;
						if (edge_total_q != {CW{1'b1}}) begin
							edge_total_q <= edge_total_q + CW'(1);
						end
						state_q <= T_RESULT;
					end
				end
				T_RESULT: begin
					if (out_load) state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// request fields and find results
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q   <= req.req_type;
			a_q     <= VW'(req.end_a);
			b_q     <= VW'(req.end_b);
			match_q <= req.edge_in_matching;
		end
		if (state_q == T_FA_WAIT && f_done) begin
			x_q  <= f_root;
			rx_q <= f_rank;
		end
		if (state_q == T_FB_WAIT && f_done) begin
			y_q  <= f_root;
			ry_q <= f_rank;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_acc_q    <= acc_q;
			res_chosen_q <= edge_total_q;
			res_done_q   <= (edge_total_q == n_eff);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.accepted     = res_acc_q;
	assign res.chosen_edges = res_chosen_q;
	assign res.tour_done    = res_done_q;

	// steps that wait on a unit
	assign f_waiting = (state_q == T_FA_WAIT) || (state_q == T_FB_WAIT)
		|| (state_q == T_LINK_WAIT);
	assign d_waiting = (state_q == T_DEG_WAIT) || (state_q == T_BUMP_WAIT);

	// forest and degree units only answer the step that waits for them
	`GTES_ASSERT_NOW(a_forest_done, clk, arst_n, f_done, f_waiting)
	`GTES_ASSERT_NOW(a_degree_done, clk, arst_n, d_done, d_waiting)
	// the sweep leaves the edge count cleared
	`GTES_ASSERT_NEXT(a_sweep_clear, clk, arst_n, state_q == T_SWEEP, edge_total_q == '0)
	// an accepted edge was counted
	`GTES_ASSERT_NOW(a_acc_counted, clk, arst_n, state_q == T_RESULT && acc_q, edge_total_q != '0)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import gtes_pkg::*;

	// request code that the block leaves unused
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_GOAL   = 1400;
	localparam int REPORT_CAP  = 40;

	typedef struct packed {
		logic                acc;
		logic [VCOUNT_W-1:0] chosen;
		logic                done;
	} pick_t;

	// shadow of the forest, degrees and edge count; queues the expected result beats
	class tour_checker;
		logic [END_W-1:0]    parent [256];
		logic [RANK_W-1:0]   rank_of [256];
		logic [DEG_W-1:0]    degree [256];
		int unsigned         edge_total;
		logic [VCOUNT_W-1:0] vertex_count;
		pick_t               pending_picks [$];
		int                  fail_count;

		function new();
			wipe();
			vertex_count = VCOUNT_RESET;
			fail_count = 0;
		endfunction

		function void wipe();
			for (int i = 0; i < 256; i++) begin
				parent[i] = 8'(i);
				rank_of[i] = '0;
				degree[i] = '0;
			end
			edge_total = 0;
		endfunction

		// register value capped at the vertex store size
		function int unsigned live_n();
			return (vertex_count < 9'd256) ? int'(vertex_count) : 256;
		endfunction

		// walk to the root, then point every node on the path straight at it
		function int unsigned root_of(int unsigned v);
			int unsigned r;
			int unsigned cur;
			int unsigned nxt;
			r = v;
			while (int'(parent[r]) != r) r = int'(parent[r]);
			cur = v;
			while (cur != r) begin
				nxt = int'(parent[cur]);
				parent[cur] = 8'(r);
				cur = nxt;
			end
			return r;
		endfunction

		// union by rank, count the edge, raise both degrees
		function void join_ends(int unsigned a, int unsigned b);
			int unsigned x;
			int unsigned y;
			x = root_of(a);
			y = root_of(b);
			if (x != y) begin
				if (rank_of[x] > rank_of[y]) begin
					parent[y] = 8'(x);
				end else if (rank_of[x] < rank_of[y]) begin
					parent[x] = 8'(y);
				end else begin
					parent[y] = 8'(x);
					if (rank_of[x] != RANK_MAX) rank_of[x] = rank_of[x] + 1'b1;
				end
			end
			if (edge_total < 511) edge_total++;
			if (degree[a] != DEG_MAX) degree[a] = degree[a] + 1'b1;
			if (degree[b] != DEG_MAX) degree[b] = degree[b] + 1'b1;
		endfunction

		function void note_edge_request(logic [REQ_W-1:0] kind, logic [END_W-1:0] a,
				logic [END_W-1:0] b, logic in_match);
			int unsigned n;
			int unsigned ia;
			int unsigned ib;
			int unsigned ra;
			int unsigned rb;
			logic took;
			pick_t p;
			n = live_n();
			ia = int'(a);
			ib = int'(b);
			took = 1'b0;
			case (kind)
				REQ_CLEAR: begin
					wipe();
				end
				REQ_MATCH: begin
					if (ia < n && ib < n) begin
						join_ends(ia, ib);
						took = 1'b1;
					end
				end
				REQ_CAND: begin
					if (ia < n && ib < n && !in_match &&
							degree[ia] < DEG_LIMIT && degree[ib] < DEG_LIMIT) begin
						ra = root_of(ia);
						rb = root_of(ib);
						// same set only closes the tour once it lacks just its last edge
						if (!(ra == rb && edge_total + 1 < n)) begin
							join_ends(ia, ib);
							took = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			p.acc = took;
			p.chosen = 9'(edge_total);
			p.done = (edge_total == n);
			pending_picks.push_back(p);
		endfunction

		task report(string msg);
			if (fail_count < REPORT_CAP) $display("ERROR: %0t %s", $realtime, msg);
			fail_count++;
		endtask

		task check_pick(logic acc, logic [VCOUNT_W-1:0] chosen, logic done);
			pick_t e;
			if (pending_picks.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			e = pending_picks.pop_front();
			if (acc !== e.acc)
				report($sformatf("accepted got %b want %b", acc, e.acc));
			if (chosen !== e.chosen)
				report($sformatf("chosen_edges got %0d want %0d", chosen, e.chosen));
			if (done !== e.done)
				report($sformatf("tour_done got %b want %b", done, e.done));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [VCOUNT_W-1:0] cfg_wr_data;

	gtes_req_if req_if ();
	gtes_res_if res_if ();

	greedy_tour_edge_selector u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.res         (res_if),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	tour_checker sb;
	int          items_sent = 0;
	bit          tx_calm = 1'b0;
	int          cycle_count = 0;

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// offer one request beat after a random gap, note it once taken
	task automatic send_req(input logic [REQ_W-1:0] kind, input logic [END_W-1:0] a,
			input logic [END_W-1:0] b, input logic in_match);
		int gap;
		gap = tx_calm ? 0 : int'($urandom_range(0, 8));
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= kind;
		req_if.end_a <= a;
		req_if.end_b <= b;
		req_if.edge_in_matching <= in_match;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		sb.note_edge_request(kind, a, b, in_match);
		items_sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle();
		req_if.valid <= 1'b0;
		while (sb.pending_picks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_vertex_count(input logic [VCOUNT_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.vertex_count = v;
	endtask

	// arbitrary requests for degenerate vertex counts
	task automatic noise_phase(input int count);
		for (int k = 0; k < count; k++) begin
			send_req(2'($urandom_range(1, 3)), 8'($urandom_range(0, 3)),
				8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3)),
				1'($urandom));
		end
	endtask

	// clear, preload a matching of paths, then greedy candidates
	task automatic tour_phase(input int count);
		int unsigned n;
		int unsigned k;
		int unsigned j;
		int unsigned tmp;
		int unsigned pick;
		int unsigned perm [256];
		int unsigned lows [$];
		int sent;
		n = sb.live_n();
		tx_calm = ($urandom_range(0, 3) == 0);
		send_req(REQ_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
		sent = 1;
		// shuffled vertex order, neighbors linked as matching edges
		for (k = 0; k < n; k++) perm[k] = k;
		for (k = n; k > 1; k--) begin
			j = $urandom_range(0, k - 1);
			tmp = perm[k - 1];
			perm[k - 1] = perm[j];
			perm[j] = tmp;
		end
		for (k = 0; k + 1 < n && sent < count; k++) begin
			if ($urandom_range(0, 2) != 0) begin
				send_req(REQ_MATCH, 8'(perm[k]), 8'(perm[k + 1]), 1'($urandom));
				sent++;
			end
		end
		// candidates mostly between vertices that can still take an edge
		while (sent < count) begin
			lows.delete();
			for (k = 0; k < n; k++) if (sb.degree[k] < DEG_LIMIT) lows.push_back(k);
			if (lows.size() == 0) break;
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				send_req(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), 1'($urandom));
			end else begin
				send_req(REQ_CAND, 8'(lows[$urandom_range(0, lows.size() - 1)]),
					8'(lows[$urandom_range(0, lows.size() - 1)]), pick == 1);
			end
			sent++;
		end
	endtask

	// result side: random stalls, two long hold-offs
	initial begin : result_sink
		int gap;
		int seen;
		bit calm;
		res_if.ready <= 1'b0;
		seen = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (seen == 150 || seen == 700) begin
				res_if.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				gap = calm ? 0 : int'($urandom_range(0, 8));
				if (gap > 0) begin
					res_if.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
			sb.check_pick(res_if.accepted, res_if.chosen_edges, res_if.tour_done);
			seen++;
			if (seen % 40 == 0) calm = ($urandom_range(0, 2) == 0);
		end
	end

	// request side and phase sequencing
	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_CLEAR;
		req_if.end_a <= '0;
		req_if.end_b <= '0;
		req_if.edge_in_matching <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset vertex count: unused code, extreme ends, matching flag, degree limit
		send_req(REQ_UNUSED, 8'd255, 8'd255, 1'b1);
		send_req(REQ_CLEAR, 8'd0, 8'd0, 1'b0);
		send_req(REQ_MATCH, 8'd0, 8'd255, 1'b1);
		send_req(REQ_CAND, 8'd255, 8'd1, 1'b0);
		send_req(REQ_CAND, 8'd0, 8'd1, 1'b1);
		send_req(REQ_CAND, 8'd255, 8'd2, 1'b0);
		settle();

		// directed, four vertices: same set early and at n-1, ends out of range, self loops
		set_vertex_count(9'd4);
		send_req(REQ_CLEAR, 8'd0, 8'd0, 1'b0);
		send_req(REQ_MATCH, 8'd0, 8'd1, 1'b0);
		send_req(REQ_MATCH, 8'd2, 8'd3, 1'b0);
		send_req(REQ_CAND, 8'd0, 8'd1, 1'b0);
		send_req(REQ_CAND, 8'd1, 8'd2, 1'b0);
		send_req(REQ_CAND, 8'd3, 8'd0, 1'b0);
		send_req(REQ_CAND, 8'd4, 8'd0, 1'b0);
		send_req(REQ_MATCH, 8'd0, 8'd5, 1'b0);
		send_req(REQ_CLEAR, 8'd3, 8'd1, 1'b1);
		send_req(REQ_MATCH, 8'd2, 8'd2, 1'b0);
		send_req(REQ_MATCH, 8'd2, 8'd2, 1'b0);
		send_req(REQ_CAND, 8'd3, 8'd3, 1'b0);
		send_req(REQ_CAND, 8'd1, 8'd3, 1'b0);
		send_req(REQ_UNUSED, 8'd1, 8'd2, 1'b0);
		settle();

		// count above range, long run without clear to saturate degrees
		set_vertex_count(9'd511);
		tx_calm = 1'b0;
		send_req(REQ_CLEAR, 8'd0, 8'd0, 1'b0);
		for (int k = 0; k < 530; k++) begin
			send_req((k % 8 == 7) ? REQ_CAND : REQ_MATCH, 8'($urandom), 8'($urandom),
				1'($urandom));
		end
		settle();

		set_vertex_count(9'd256);
		tour_phase(320);
		for (int v = 0; v < 3; v++) begin
			settle();
			set_vertex_count(9'(v));
			noise_phase(12);
		end
		settle();
		set_vertex_count(9'd3);
		tour_phase(20);
		settle();
		set_vertex_count(9'd255);
		tour_phase(120);

		// random small graphs
		while (items_sent < ITEM_GOAL) begin
			settle();
			set_vertex_count(($urandom_range(0, 7) == 0) ? 9'($urandom_range(17, 64))
				: 9'($urandom_range(3, 16)));
			tour_phase(60);
		end

		settle();
		repeat (60) @(posedge clk);
		if (sb.pending_picks.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_picks.size()));
		if (sb.fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
